// ===== rtl/mcr_pkg.sv =====
// Shared types, widths and constant tables for the coefficient requantiser.
// Used by mcr_root_pipe and mp3_coefficient_requantiser_unit; no dependencies.
package mcr_pkg;

    localparam int FRACTION_BITS = 12;

    localparam int Q_W       = 15;          // quantised value and its magnitude
    localparam int R_W       = 21;          // cube root, 16 fraction bits
    localparam int R2_W      = 2 * R_W;     // running square of the root
    localparam int RAD_SHIFT = 48;
    localparam int REM_W     = 63;          // radicand remainder
    localparam int D_W       = REM_W + 3;   // trial increment of the cube
    localparam int P_W       = Q_W + R_W;   // |q|^(4/3), 16 fraction bits
    localparam int P_LO_W    = P_W / 2;
    localparam int P_HI_W    = P_W - P_LO_W;
    localparam int G_W       = 29;          // 2^(frac/4) in Q28
    localparam int PP_LO_W   = P_LO_W + G_W;
    localparam int PP_HI_W   = P_HI_W + G_W;
    localparam int T_W       = P_W + G_W + 1;
    localparam int MAG_W     = 31;
    localparam int EXP_W     = 8;
    localparam int E_W       = 10;          // quarter-step exponent, signed
    localparam int SFS_W     = 5;           // scalefactor plus pretab
    localparam int BAND_W    = 5;
    localparam int NUM_BANDS = 22;

    localparam int RND_SHIFT = 43 - FRACTION_BITS;
    localparam int OUT_SHIFT = 44 - FRACTION_BITS;

    localparam logic [E_W-1:0] GAIN_OFFSET = E_W'(210);

    localparam logic [1:0] KIND_LONG  = 2'd0;
    localparam logic [1:0] KIND_MIXED = 2'd1;
    localparam logic [1:0] KIND_SHORT = 2'd2;

    typedef struct packed {
        logic             neg;
        logic [EXP_W-1:0] expo;
        logic [1:0]       frac;
        logic [Q_W-1:0]   mag_q;
    } t_side;

    function automatic logic [1:0] pretab(input logic [BAND_W-1:0] band);
        logic [1:0] v;
        case (band)
            5'd11, 5'd12, 5'd13, 5'd14: v = 2'd1;
            5'd15, 5'd16, 5'd20:        v = 2'd2;
            5'd17, 5'd18, 5'd19:        v = 2'd3;
            default:                    v = 2'd0;
        endcase
        return v;
    endfunction

    function automatic logic [G_W-1:0] quarter_gain(input logic [1:0] frac);
        logic [G_W-1:0] g;
        case (frac)
            2'd0:    g = G_W'(268435456);
            2'd1:    g = G_W'(319225354);
            2'd2:    g = G_W'(379625062);
            default: g = G_W'(451452825);
        endcase
        return g;
    endfunction

endpackage

// ===== rtl/mcr_root_pipe.sv =====
// Pipelined cube root of |q| * 2^48, one result bit per stage after the load stage.
// Carries the item's side data alongside. Depends on mcr_pkg.
module mcr_root_pipe (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  mcr_pkg::t_side           i_side,
    output logic                     o_valid,
    input  logic                     i_stall,
    output mcr_pkg::t_side           o_side,
    output logic [mcr_pkg::R_W-1:0]  o_root
);

    localparam int NS = mcr_pkg::R_W + 1;

    logic                         r_valid [0:NS-1];
    mcr_pkg::t_side               r_side  [0:NS-1];
    logic [mcr_pkg::REM_W-1:0]    r_rem   [0:NS-1];
    logic [mcr_pkg::R_W-1:0]      r_root  [0:NS-1];
    logic [mcr_pkg::R2_W-1:0]     r_sq    [0:NS-1];
    logic                         ready   [0:NS-1];

    // a stage may load when it is empty or its item moves on
    always_comb begin
        ready[NS-1] = !r_valid[NS-1] || !i_stall;
        for (int k = NS - 2; k >= 0; k--) begin
            ready[k] = !r_valid[k] || ready[k+1];
        end
    end

    assign o_stall = !ready[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid[0] <= 1'b0;
        end else if (ready[0]) begin
            r_valid[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready[0] && i_valid) begin
            r_side[0] <= i_side;
            r_rem[0]  <= mcr_pkg::REM_W'(i_side.mag_q) << mcr_pkg::RAD_SHIFT;
            r_root[0] <= '0;
            r_sq[0]   <= '0;
        end
    end

    for (genvar k = 1; k < NS; k++) begin : g_stage
        localparam int B = mcr_pkg::R_W - k;

        logic [mcr_pkg::D_W-1:0]   d;
        logic                      take;
        logic [mcr_pkg::REM_W-1:0] n_rem;
        logic [mcr_pkg::R_W-1:0]   n_root;
        logic [mcr_pkg::R2_W-1:0]  n_sq;

        // (r + 2^B)^3 - r^3 = 3 r^2 2^B + 3 r 2^2B + 2^3B
        always_comb begin
            d = (mcr_pkg::D_W'(r_sq[k-1]) << B)
              + (mcr_pkg::D_W'(r_sq[k-1]) << (B + 1))
              + (mcr_pkg::D_W'(r_root[k-1]) << (2 * B))
              + (mcr_pkg::D_W'(r_root[k-1]) << (2 * B + 1))
              + (mcr_pkg::D_W'(1) << (3 * B));
            take = d <= mcr_pkg::D_W'(r_rem[k-1]);
            if (take) begin
                n_rem  = mcr_pkg::REM_W'(mcr_pkg::D_W'(r_rem[k-1]) - d);
                n_root = r_root[k-1] | (mcr_pkg::R_W'(1) << B);
                n_sq   = r_sq[k-1] + (mcr_pkg::R2_W'(r_root[k-1]) << (B + 1))
                       + (mcr_pkg::R2_W'(1) << (2 * B));
            end else begin
                n_rem  = r_rem[k-1];
                n_root = r_root[k-1];
                n_sq   = r_sq[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (ready[k]) begin
                r_valid[k] <= r_valid[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (ready[k] && r_valid[k-1]) begin
                r_side[k] <= r_side[k-1];
                r_rem[k]  <= n_rem;
                r_root[k] <= n_root;
                r_sq[k]   <= n_sq;
            end
        end
    end

    assign o_valid = r_valid[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_root  = r_root[NS-1];

endmodule

// ===== rtl/mp3_coefficient_requantiser_unit.sv =====
// Top level of the coefficient requantiser: exponent decode, product stages, output register.
// Depends on mcr_pkg and mcr_root_pipe.

// Takes one quantized coefficient per cycle while o_stall is low, with its band
// scale data, and returns sign, a 31-bit magnitude |q|^(4/3)*2^(frac/4) with
// mcr_pkg::FRACTION_BITS fraction bits, and the power-of-two exponent floor(E/4).
// One item per cycle sustained while i_stall is low. The path is an input register,
// 21 cube-root stages (one root bit each), the |q|*root multiply, the split gain
// multiply, and the round and saturate stage that feeds the output register. Any
// stage holding a bubble still loads while the output is stalled.
module mp3_coefficient_requantiser_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [14:0]            i_quant_value,
    input  logic [7:0]                    i_global_gain,
    input  logic                          i_scale_step_coarse,
    input  logic                          i_pre_emphasis,
    input  logic [1:0]                    i_coeff_kind,
    input  logic [4:0]                    i_band_index,
    input  logic [3:0]                    i_band_scalefactor,
    input  logic [2:0]                    i_window_gain,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic                          o_sample_negative,
    output logic [30:0]                   o_sample_magnitude,
    output logic signed [7:0]             o_sample_exponent
);

    // ---- exponent and side data ----
    mcr_pkg::t_side                  in_side;
    logic [mcr_pkg::Q_W-1:0]         mag_q;
    logic [mcr_pkg::SFS_W-1:0]       sf_sum;
    logic [mcr_pkg::E_W-1:0]         sf_term;
    logic [mcr_pkg::E_W-1:0]         wg_term;
    logic [mcr_pkg::E_W-1:0]         e_q;

    always_comb begin
        mag_q = i_quant_value[14] ? mcr_pkg::Q_W'(-i_quant_value)
                                  : mcr_pkg::Q_W'(i_quant_value);
        sf_sum = mcr_pkg::SFS_W'(i_band_scalefactor);
        if (i_coeff_kind == mcr_pkg::KIND_LONG && i_pre_emphasis
                && i_band_index < mcr_pkg::BAND_W'(mcr_pkg::NUM_BANDS)) begin
            sf_sum = sf_sum + mcr_pkg::SFS_W'(mcr_pkg::pretab(i_band_index));
        end
        sf_term = i_scale_step_coarse ? (mcr_pkg::E_W'(sf_sum) << 2)
                                      : (mcr_pkg::E_W'(sf_sum) << 1);
        // kind code 3 decodes as a short window
        wg_term = (i_coeff_kind >= mcr_pkg::KIND_SHORT) ? (mcr_pkg::E_W'(i_window_gain) << 3)
                                                        : '0;
        e_q = mcr_pkg::E_W'(i_global_gain) - mcr_pkg::GAIN_OFFSET - wg_term - sf_term;
        in_side.neg   = i_quant_value[14] && (mag_q != '0);
        in_side.expo  = e_q[mcr_pkg::E_W-1:2];
        in_side.frac  = e_q[1:0];
        in_side.mag_q = mag_q;
    end

    // ---- cube root ----
    logic                        root_valid;
    logic                        root_stall;
    mcr_pkg::t_side              root_side;
    logic [mcr_pkg::R_W-1:0]     root_val;

    logic ready_p;
    logic ready_m;
    logic ready_o;

    mcr_root_pipe u_root (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_side  (in_side),
        .o_valid (root_valid),
        .i_stall (root_stall),
        .o_side  (root_side),
        .o_root  (root_val)
    );

    assign root_stall = !ready_p;

    // ---- product and gain stages ----
    logic                          r_vp;
    mcr_pkg::t_side                r_side_p;
    logic [mcr_pkg::P_W-1:0]       r_prod;

    logic                          r_vm;
    mcr_pkg::t_side                r_side_m;
    logic [mcr_pkg::PP_LO_W-1:0]   r_pp_lo;
    logic [mcr_pkg::PP_HI_W-1:0]   r_pp_hi;

    logic                          r_vo;
    logic                          r_neg_o;
    logic [mcr_pkg::MAG_W-1:0]     r_mag_o;
    logic [mcr_pkg::EXP_W-1:0]     r_exp_o;

    logic [mcr_pkg::G_W-1:0]       gain;
    logic [mcr_pkg::T_W-1:0]       n_t;
    logic [mcr_pkg::T_W-1:0]       n_shifted;
    logic [mcr_pkg::MAG_W-1:0]     n_mag;

    assign ready_o = !r_vo || !i_stall;
    assign ready_m = !r_vm || ready_o;
    assign ready_p = !r_vp || ready_m;

    assign gain = mcr_pkg::quarter_gain(r_side_p.frac);

    always_comb begin
        n_t = (mcr_pkg::T_W'(r_pp_hi) << mcr_pkg::P_LO_W) + mcr_pkg::T_W'(r_pp_lo)
            + (mcr_pkg::T_W'(1) << mcr_pkg::RND_SHIFT);
        n_shifted = n_t >> mcr_pkg::OUT_SHIFT;
        n_mag = (|n_shifted[mcr_pkg::T_W-1:mcr_pkg::MAG_W]) ? '1
                                                           : n_shifted[mcr_pkg::MAG_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vp <= 1'b0;
            r_vm <= 1'b0;
            r_vo <= 1'b0;
        end else begin
            if (ready_p) begin
                r_vp <= root_valid;
            end
            if (ready_m) begin
                r_vm <= r_vp;
            end
            if (ready_o) begin
                r_vo <= r_vm;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ready_p && root_valid) begin
            r_side_p <= root_side;
            r_prod   <= mcr_pkg::P_W'(root_side.mag_q) * mcr_pkg::P_W'(root_val);
        end
        if (ready_m && r_vp) begin
            r_side_m <= r_side_p;
            r_pp_lo  <= mcr_pkg::PP_LO_W'(r_prod[mcr_pkg::P_LO_W-1:0])
                      * mcr_pkg::PP_LO_W'(gain);
            r_pp_hi  <= mcr_pkg::PP_HI_W'(r_prod[mcr_pkg::P_W-1:mcr_pkg::P_LO_W])
                      * mcr_pkg::PP_HI_W'(gain);
        end
        if (ready_o && r_vm) begin
            r_neg_o <= r_side_m.neg;
            r_exp_o <= r_side_m.expo;
            r_mag_o <= n_mag;
        end
    end

    assign o_valid            = r_vo;
    assign o_sample_negative  = r_neg_o;
    assign o_sample_magnitude = r_mag_o;
    assign o_sample_exponent  = $signed(r_exp_o);

endmodule
